>>> design/pq4fs_pkg.sv
// Shared types, constants and table lookup for the 4-bit fast-scan block scorer.
package pq4fs_pkg;

    localparam int LANES      = 32;
    localparam int HALF_LANES = LANES / 2;
    localparam int SUM_W      = 16;
    localparam int DIST_W     = 16;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int BYTE_W     = 8;
    localparam int NIBBLE_W   = 4;
    localparam int WORD_W     = 64;
    localparam int TABLE_SIZE = 16;

    localparam logic [LANE_IDX_W-1:0] LAST_LANE = LANE_IDX_W'(LANES - 1);

    typedef logic [SUM_W-1:0]                t_sum;
    typedef logic [LANES-1:0][SUM_W-1:0]     t_lane_sums;
    typedef logic [BYTE_W-1:0]               t_byte;
    typedef logic [NIBBLE_W-1:0]             t_nibble;

    // One subspace row as it sits in the input register.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] table_low_entries;
        logic [WORD_W-1:0] table_high_entries;
        logic [WORD_W-1:0] codes_low_bytes;
        logic [WORD_W-1:0] codes_high_bytes;
        logic              final_subspace;
    } t_row;

    // Picks one of the sixteen byte-wide distance table entries.
    function automatic t_byte table_entry(input logic [WORD_W-1:0] lo,
                                          input logic [WORD_W-1:0] hi,
                                          input t_nibble           idx);
        logic [2*WORD_W-1:0] tbl;
        tbl = {hi, lo};
        return tbl[{idx, 3'b000} +: BYTE_W];
    endfunction

    // Picks code byte j of the sixteen carried by a row.
    function automatic t_byte code_byte(input logic [WORD_W-1:0] lo,
                                        input logic [WORD_W-1:0] hi,
                                        input int                j);
        logic [2*WORD_W-1:0] codes;
        codes = {hi, lo};
        return codes[j*BYTE_W +: BYTE_W];
    endfunction

endpackage

>>> design/pq4fs_req_if.sv
// Request channel carrying one subspace row of tables and codes.
interface pq4fs_req_if;
    import pq4fs_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] table_low_entries;
    logic [WORD_W-1:0] table_high_entries;
    logic [WORD_W-1:0] codes_low_bytes;
    logic [WORD_W-1:0] codes_high_bytes;
    logic              final_subspace;

    modport source (
        output valid, table_low_entries, table_high_entries,
               codes_low_bytes, codes_high_bytes, final_subspace,
        input  ready
    );
    modport sink (
        input  valid, table_low_entries, table_high_entries,
               codes_low_bytes, codes_high_bytes, final_subspace,
        output ready
    );
endinterface

>>> design/pq4fs_res_if.sv
// Result channel carrying one lane sum.
interface pq4fs_res_if;
    import pq4fs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LANE_IDX_W-1:0] lane_index;
    logic [DIST_W-1:0]     distance_sum;
    logic                  final_lane;

    modport source (
        output valid, lane_index, distance_sum, final_lane,
        input  ready
    );
    modport sink (
        input  valid, lane_index, distance_sum, final_lane,
        output ready
    );
endinterface

>>> design/pq4_fast_scan_block.sv
// Top level of the 4-bit product-quantization fast-scan block scorer.
// A final row passes the input register, then its sums load the snapshot register.
// Throughput: one row per cycle unless a final row is held off; the 32 lane sums then
// drain one per ready cycle from a snapshot shift register as later rows keep accumulating.
// A final row is held off while the previous final row or its draining sums are in flight.
// Synchronous active-low reset clears the accumulators, the input stage and the drain.
module pq4_fast_scan_block (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pq4fs_req_if.sink    i_req,
    pq4fs_res_if.source  o_res
);
    import pq4fs_pkg::*;

    t_row                  r_row;
    t_row                  n_row;
    t_lane_sums            totals;
    t_lane_sums            r_buf;
    t_lane_sums            n_buf;
    logic                  r_buf_busy;
    logic                  n_buf_busy;
    logic [LANE_IDX_W-1:0] r_out_idx;
    logic [LANE_IDX_W-1:0] n_out_idx;
    logic                  row_final;
    logic                  req_take;
    logic                  res_take;

    assign row_final = r_row.valid && r_row.final_subspace;

    // A final request needs the snapshot buffer free when it leaves the input stage.
    assign i_req.ready = !(i_req.valid && i_req.final_subspace && (r_buf_busy || row_final));
    assign req_take    = i_req.valid && i_req.ready;
    assign res_take    = o_res.valid && o_res.ready;

    always_comb begin
        n_row                    = r_row;
        n_row.valid              = req_take;
        if (req_take) begin
            n_row.table_low_entries  = i_req.table_low_entries;
            n_row.table_high_entries = i_req.table_high_entries;
            n_row.codes_low_bytes    = i_req.codes_low_bytes;
            n_row.codes_high_bytes   = i_req.codes_high_bytes;
            n_row.final_subspace     = i_req.final_subspace;
        end
    end

    pq4fs_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_row    (r_row),
        .o_totals (totals)
    );

    always_comb begin
        n_buf      = r_buf;
        n_buf_busy = r_buf_busy;
        n_out_idx  = r_out_idx;
        if (row_final) begin
            n_buf      = totals;
            n_buf_busy = 1'b1;
            n_out_idx  = '0;
        end else if (res_take) begin
            for (int k = 0; k < LANES - 1; k++) begin
                n_buf[k] = r_buf[k+1];
            end
            n_out_idx = r_out_idx + 1'b1;
            if (r_out_idx == LAST_LANE) begin
                n_buf_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row.valid <= 1'b0;
            r_buf_busy  <= 1'b0;
            r_out_idx   <= '0;
        end else begin
            r_row.valid <= n_row.valid;
            r_buf_busy  <= n_buf_busy;
            r_out_idx   <= n_out_idx;
        end
        r_row.table_low_entries  <= n_row.table_low_entries;
        r_row.table_high_entries <= n_row.table_high_entries;
        r_row.codes_low_bytes    <= n_row.codes_low_bytes;
        r_row.codes_high_bytes   <= n_row.codes_high_bytes;
        r_row.final_subspace     <= n_row.final_subspace;
        r_buf                    <= n_buf;
    end

    assign o_res.valid        = r_buf_busy;
    assign o_res.lane_index   = r_out_idx;
    assign o_res.distance_sum = DIST_W'(r_buf[0]);
    assign o_res.final_lane   = (r_out_idx == LAST_LANE);

`ifndef SYNTH
    a_snapshot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_final |-> !r_buf_busy)
        else $error("final row reached the snapshot while sums were draining");

    a_final_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_take && i_req.final_subspace) |=> (row_final && !r_buf_busy))
        else $error("accepted final request found the snapshot busy");

    a_drain_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_buf_busy) |-> (r_out_idx == '0))
        else $error("drain did not start at lane zero");

    a_drain_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_take && o_res.final_lane && !row_final) |=> !r_buf_busy)
        else $error("drain kept going after the last lane");
`endif

endmodule

>>> design/pq4fs_accum.sv
// Lane accumulators: table lookup and add for all 32 lanes of one row per cycle.
module pq4fs_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pq4fs_pkg::t_row       i_row,
    output pq4fs_pkg::t_lane_sums o_totals
);
    import pq4fs_pkg::*;

    t_lane_sums r_acc;
    t_lane_sums n_acc;

    // Low nibble of code byte j feeds lane j, high nibble feeds lane j+16.
    always_comb begin
        t_byte code;
        for (int j = 0; j < HALF_LANES; j++) begin
            code = code_byte(i_row.codes_low_bytes, i_row.codes_high_bytes, j);
            o_totals[j] = r_acc[j] + SUM_W'(table_entry(i_row.table_low_entries,
                i_row.table_high_entries, code[NIBBLE_W-1:0]));
            o_totals[j+HALF_LANES] = r_acc[j+HALF_LANES] +
                SUM_W'(table_entry(i_row.table_low_entries,
                i_row.table_high_entries, code[BYTE_W-1:NIBBLE_W]));
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_row.valid) begin
            n_acc = i_row.final_subspace ? '0 : o_totals;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule
